### design/csr_pkg.sv
// Shared types and constants for the congruence system solver.
// No dependencies; compiled first.
package csr_pkg;

	localparam int WORD_BITS_DEF = 64;
	localparam int X_BITS = 64;
	localparam logic [6:0] FULL_STEPS = 7'd64;

	typedef enum logic [1:0] {
		ST_SOLVED   = 2'd0,
		ST_CONFLICT = 2'd1,
		ST_OVERFLOW = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		OP_DIV    = 2'd0,
		OP_MULMOD = 2'd1,
		OP_MUL    = 2'd2
	} alu_op_t;

	typedef struct packed {
		logic    start;
		alu_op_t op;
		logic [6:0] steps;
	} alu_cmd_t;

	typedef struct packed {
		logic done;
		logic ovf;
	} alu_rsp_t;

	typedef enum logic [4:0] {
		S_IDLE, S_LOAD, S_FRES, S_GCD, S_GCD_W, S_DMOD_W, S_A_W, S_L_W,
		S_N_W, S_K_W, S_AM_W, S_INV, S_Q_W, S_QS_W, S_T_W, S_P_W, S_FIN
	} seq_state_t;

endpackage

### design/csr_in_if.sv
// Input channel of the solver: one congruence per transfer.
// Standalone; no package needed.
interface csr_in_if;
	logic               valid;
	logic               ready;
	logic signed [63:0] residue;
	logic [62:0]        modulus;
	logic               last;

	modport source (output valid, residue, modulus, last, input ready);
	modport sink (input valid, residue, modulus, last, output ready);
endinterface

### design/csr_out_if.sv
// Result channel of the solver: one combined congruence per transfer.
// Standalone; no package needed.
interface csr_out_if;
	logic        valid;
	logic        ready;
	logic [62:0] solution_residue;
	logic [62:0] solution_modulus;
	logic [1:0]  status;

	modport source (output valid, solution_residue, solution_modulus, status, input ready);
	modport sink (input valid, solution_residue, solution_modulus, status, output ready);
endinterface

### design/congruence_system_solver.sv
// Top level of the congruence system solver: sequencer, running state and
// result register around one csr_alu. Uses csr_pkg, csr_in_if, csr_out_if.
//
// Folds a stream of congruences x = residue (mod modulus) into one
// congruence x = solution_residue (mod solution_modulus), moduli need not be
// coprime. A modulus of 0 counts as 1. One result transfer follows each item
// with last set; status 0 solved, 1 conflicting, 2 modulus above
// 2^(WORD_BITS-1)-1; on failure both numeric fields read 0 and the rest of
// the system up to last is skipped. The block takes one item at a time and
// drops ready until that item is folded. All arithmetic runs through one
// bit-serial unit, one bit per cycle with a DW = WORD_BITS-1 bit word: the
// floor residue is a full 64-bit pass, each Euclid round of the gcd one DW-bit
// divide, each round of the modular inverse a divide, then a multiply mod n,
// plus up to eight more DW-bit passes per fold. A first item in range needs
// only the floor residue; a skipped item goes straight to the finish. A
// finished result sits in an output register, so the next item is taken
// while it waits unless another last item finishes first.
module congruence_system_solver import csr_pkg::*; #(
	parameter int WORD_BITS = WORD_BITS_DEF
) (
	input  logic   clk,
	input  logic   arst_n,
	csr_in_if.sink items,
	csr_out_if.source results
);

	localparam int DW = WORD_BITS - 1;
	localparam logic [62:0] LIMIT63 = 63'((64'd1 << DW) - 64'd1);
	localparam logic [6:0] DW_STEPS = 7'(DW);

	function automatic logic [X_BITS-1:0] al(input logic [DW-1:0] v);
		al = {v, {(X_BITS-DW){1'b0}}};
	endfunction

	seq_state_t state_q, state_n;

	// running state
	logic [DW-1:0] rr_q, rm_q;
	logic          first_q;
	status_t       stat_q;

	// latched item and fold scratch
	logic [63:0]   res_q;
	logic [DW-1:0] m2_q, r2_q, ga_q, gb_q, g_q, dg_q, a_q, l_q, n_q, k_q;
	logic [DW-1:0] os_q, s_q, t_q;
	logic          big_q, last_q, neg_q;

	// result register
	logic          ov_q;
	logic [62:0]   sol_r_q, sol_m_q;
	status_t       sol_st_q;

	alu_cmd_t          cmd;
	alu_rsp_t          rsp;
	logic [X_BITS-1:0] alu_x, alu_quo;
	logic [DW-1:0]     alu_s, alu_acc, alu_q;

	logic [62:0]   mfix;
	logic [63:0]   mag;
	logic [DW-1:0] fres, dif, ns;
	logic          skip, done, emit;

	csr_alu #(.DW(DW)) u_alu (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.x      (alu_x),
		.s      (alu_s),
		.n      (n_q),
		.rsp    (rsp),
		.quo    (alu_quo),
		.acc    (alu_acc)
	);

	assign done = rsp.done;
	assign alu_q = alu_quo[DW-1:0];
	assign mfix = (items.modulus == 63'd0) ? 63'd1 : items.modulus;
	assign mag = res_q[63] ? (~res_q + 64'd1) : res_q;
	// floor residue: negative values fold up from the magnitude remainder
	assign fres = (res_q[63] && alu_acc != '0) ? (m2_q - alu_acc) : alu_acc;
	assign skip = !first_q && stat_q != ST_SOLVED;
	assign dif = (r2_q < rr_q) ? (rr_q - r2_q) : (r2_q - rr_q);
	// next Bezout coefficient, kept in [0, n)
	assign ns = (os_q >= alu_acc) ? (os_q - alu_acc) : (os_q + (n_q - alu_acc));
	assign emit = state_q == S_FIN && last_q && (!ov_q || results.ready);

	// next state
	always_comb begin
		state_n = state_q;
		case (state_q)
			S_IDLE: if (items.valid) state_n = S_LOAD;
			S_LOAD: state_n = (skip || big_q) ? S_FIN : S_FRES;
			S_FRES: if (done) state_n = first_q ? S_FIN : S_GCD;
			S_GCD: state_n = (gb_q == '0) ? S_DMOD_W : S_GCD_W;
			S_GCD_W: if (done) state_n = S_GCD;
			S_DMOD_W: if (done) state_n = (alu_acc != '0) ? S_FIN : S_A_W;
			S_A_W: if (done) state_n = S_L_W;
			S_L_W: if (done) state_n = rsp.ovf ? S_FIN : S_N_W;
			S_N_W: if (done) state_n = (alu_q == DW'(1)) ? S_FIN : S_K_W;
			S_K_W: if (done) state_n = S_AM_W;
			S_AM_W: if (done) state_n = S_INV;
			S_INV: state_n = (gb_q == '0) ? S_T_W : S_Q_W;
			S_Q_W: if (done) state_n = S_QS_W;
			S_QS_W: if (done) state_n = S_INV;
			S_T_W: if (done) state_n = S_P_W;
			S_P_W: if (done) state_n = S_FIN;
			S_FIN: if (!last_q || emit) state_n = S_IDLE;
			default: state_n = S_IDLE;
		endcase
	end

	// unit commands
	always_comb begin
		cmd.start = 1'b0;
		cmd.op = OP_DIV;
		cmd.steps = DW_STEPS;
		alu_x = al(ga_q);
		alu_s = gb_q;
		items.ready = state_q == S_IDLE;
		case (state_q)
			S_LOAD: begin
				cmd.start = !(skip || big_q);
				cmd.steps = FULL_STEPS;
				alu_x = mag;
				alu_s = m2_q;
			end
			S_GCD: begin
				cmd.start = 1'b1;
				if (gb_q == '0) begin
					alu_x = al(dif);
					alu_s = ga_q;
				end
			end
			S_DMOD_W: begin
				cmd.start = done && alu_acc == '0;
				alu_x = al(rm_q);
				alu_s = g_q;
			end
			S_A_W: begin
				cmd.start = done;
				cmd.op = OP_MUL;
				alu_x = al(m2_q);
				alu_s = alu_q;
			end
			S_L_W: begin
				cmd.start = done && !rsp.ovf;
				alu_x = al(m2_q);
				alu_s = g_q;
			end
			S_N_W: begin
				cmd.start = done && alu_q != DW'(1);
				alu_x = al(dg_q);
				alu_s = alu_q;
			end
			S_K_W: begin
				cmd.start = done;
				alu_x = al(a_q);
				alu_s = n_q;
			end
			S_INV: begin
				cmd.start = 1'b1;
				if (gb_q == '0) begin
					cmd.op = OP_MULMOD;
					alu_x = al(k_q);
					alu_s = os_q;
				end
			end
			S_Q_W: begin
				cmd.start = done;
				cmd.op = OP_MULMOD;
				alu_x = al(alu_q);
				alu_s = s_q;
			end
			S_T_W: begin
				cmd.start = done;
				cmd.op = OP_MUL;
				alu_x = al(alu_acc);
				alu_s = rm_q;
			end
			default: ;
		endcase
	end

	// control and running state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			first_q <= 1'b1;
			stat_q <= ST_SOLVED;
			rr_q <= '0;
			rm_q <= DW'(1);
			ov_q <= 1'b0;
		end else begin
			state_q <= state_n;
			// a new result may load in the cycle the old one transfers
			if (emit) begin
				ov_q <= 1'b1;
			end else if (results.ready) begin
				ov_q <= 1'b0;
			end
			case (state_q)
				S_LOAD: if (!skip && big_q) begin
					first_q <= 1'b0;
					stat_q <= ST_OVERFLOW;
				end
				S_FRES: if (done && first_q) begin
					first_q <= 1'b0;
					stat_q <= ST_SOLVED;
					rr_q <= fres;
					rm_q <= m2_q;
				end
				S_DMOD_W: if (done && alu_acc != '0) stat_q <= ST_CONFLICT;
				S_L_W: if (done && rsp.ovf) stat_q <= ST_OVERFLOW;
				S_N_W: if (done && alu_q == DW'(1)) rm_q <= l_q;
				S_P_W: if (done) begin
					rr_q <= rr_q + alu_acc;
					rm_q <= l_q;
				end
				S_FIN: if (emit) begin
					first_q <= 1'b1;
					stat_q <= ST_SOLVED;
					rr_q <= '0;
					rm_q <= DW'(1);
				end
				default: ;
			endcase
		end
	end

	// scratch and result payload
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: if (items.valid) begin
				res_q <= items.residue;
				m2_q <= mfix[DW-1:0];
				big_q <= mfix > LIMIT63;
				last_q <= items.last;
			end
			S_FRES: if (done) begin
				r2_q <= fres;
				ga_q <= rm_q;
				gb_q <= m2_q;
			end
			S_GCD: if (gb_q == '0) begin
				g_q <= ga_q;
				neg_q <= r2_q < rr_q;
			end
			S_GCD_W: if (done) begin
				ga_q <= gb_q;
				gb_q <= alu_acc;
			end
			S_DMOD_W: if (done) dg_q <= alu_q;
			S_A_W: if (done) a_q <= alu_q;
			S_L_W: if (done) l_q <= alu_acc;
			S_N_W: if (done) n_q <= alu_q;
			S_K_W: if (done) k_q <= (neg_q && alu_acc != '0) ? (n_q - alu_acc) : alu_acc;
			S_AM_W: if (done) begin
				ga_q <= alu_acc;
				gb_q <= n_q;
				os_q <= DW'(1);
				s_q <= '0;
			end
			S_Q_W: if (done) t_q <= alu_acc;
			S_QS_W: if (done) begin
				ga_q <= gb_q;
				gb_q <= t_q;
				os_q <= s_q;
				s_q <= ns;
			end
			S_FIN: if (emit) begin
				sol_st_q <= stat_q;
				sol_r_q <= (stat_q == ST_SOLVED) ? 63'(rr_q) : 63'd0;
				sol_m_q <= (stat_q == ST_SOLVED) ? 63'(rm_q) : 63'd0;
			end
			default: ;
		endcase
	end

	assign results.valid = ov_q;
	assign results.solution_residue = sol_r_q;
	assign results.solution_modulus = sol_m_q;
	assign results.status = sol_st_q;

`ifndef SYNTH
	a_busy_no_ready: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_IDLE) |-> !items.ready) else $error("ready while folding");
	a_res_range: assert property (@(posedge clk) disable iff (!arst_n)
		(stat_q == ST_SOLVED && !first_q && state_q == S_FIN) |-> rr_q < rm_q)
		else $error("running residue not below running modulus");
	a_rearm: assert property (@(posedge clk) disable iff (!arst_n)
		emit |=> (first_q && stat_q == ST_SOLVED)) else $error("no rearm after result");
`endif

endmodule

### design/csr_alu.sv
// Shared bit-serial arithmetic unit: restoring divide, modular multiply,
// and multiply with overflow detect, one bit per cycle. Uses csr_pkg.
module csr_alu import csr_pkg::*; #(
	parameter int DW = WORD_BITS_DEF - 1
) (
	input  logic                clk,
	input  logic                arst_n,
	input  alu_cmd_t            cmd,
	input  logic [X_BITS-1:0]   x,
	input  logic [DW-1:0]       s,
	input  logic [DW-1:0]       n,
	output alu_rsp_t            rsp,
	output logic [X_BITS-1:0]   quo,
	output logic [DW-1:0]       acc
);

	logic [X_BITS-1:0] x_q, x_n;
	logic [DW-1:0]     s_q;
	logic [DW:0]       acc_q, acc_n;
	logic [6:0]        cnt_q;
	logic              busy_q, done_q, ovf_q, ovf_n;
	alu_op_t           op_q;
	logic [DW:0]       t, dbl, sm;
	logic [DW+1:0]     pr;
	logic              ge;

	// divisor / addend is held for the whole pass
	always_comb begin
		t = {acc_q[DW-1:0], x_q[X_BITS-1]};
		ge = t >= {1'b0, s_q};
		dbl = {acc_q[DW-1:0], 1'b0};
		if (dbl >= {1'b0, n}) begin
			dbl = dbl - {1'b0, n};
		end
		sm = dbl + (x_q[X_BITS-1] ? {1'b0, s_q} : '0);
		if (sm >= {1'b0, n}) begin
			sm = sm - {1'b0, n};
		end
		pr = {1'b0, acc_q[DW-1:0], 1'b0} + (x_q[X_BITS-1] ? {2'b00, s_q} : '0);
		ovf_n = ovf_q;
		case (op_q)
			OP_DIV: begin
				acc_n = ge ? (t - {1'b0, s_q}) : t;
				x_n = {x_q[X_BITS-2:0], ge};
			end
			OP_MULMOD: begin
				acc_n = sm;
				x_n = {x_q[X_BITS-2:0], 1'b0};
			end
			OP_MUL: begin
				acc_n = pr[DW:0];
				x_n = {x_q[X_BITS-2:0], 1'b0};
				// sticky: once past the word limit the product is dead
				if (pr[DW+1:DW] != 2'b00) begin
					ovf_n = 1'b1;
				end
			end
			default: begin
				acc_n = acc_q;
				x_n = x_q;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (cmd.start) begin
				busy_q <= 1'b1;
				cnt_q <= cmd.steps;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 7'd1;
				if (cnt_q == 7'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			x_q <= x;
			s_q <= s;
			acc_q <= '0;
			ovf_q <= 1'b0;
			op_q <= cmd.op;
		end else if (busy_q) begin
			x_q <= x_n;
			acc_q <= acc_n;
			ovf_q <= ovf_n;
		end
	end

	assign rsp.done = done_q;
	assign rsp.ovf = ovf_q;
	assign quo = x_q;
	assign acc = acc_q[DW-1:0];

`ifndef SYNTH
	a_no_restart: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> !cmd.start) else $error("alu restarted while busy");
	a_div_rem: assert property (@(posedge clk) disable iff (!arst_n)
		(busy_q && op_q == OP_DIV) |-> acc_q < {1'b0, s_q})
		else $error("partial remainder not below divisor");
	a_mulmod_rng: assert property (@(posedge clk) disable iff (!arst_n)
		(busy_q && op_q == OP_MULMOD) |-> acc_q < {1'b0, n})
		else $error("modular accumulator out of range");
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |=> !done_q) else $error("done held more than one cycle");
`endif

endmodule

### bench/congruence_system_solver_test.sv
`timescale 1ns / 1ps
// Self-checking bench for congruence_system_solver: directed and random systems of congruences.
// Depends on csr_pkg, csr_in_if, csr_out_if and the solver RTL.
module congruence_system_solver_test;
	import csr_pkg::*;

	localparam logic [63:0] MOD_CEIL = 64'h7FFF_FFFF_FFFF_FFFF;
	localparam longint unsigned CYCLE_LIMIT = 100_000_000;
	localparam int SETTLE_CYCLES = 200;

	typedef struct packed {
		logic [62:0] sol_res;
		logic [62:0] sol_mod;
		status_t     status;
	} solution_t;

	logic clk;
	logic arst_n;

	csr_in_if  items_ch ();
	csr_out_if results_ch ();

	congruence_system_solver dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.items   (items_ch.sink),
		.results (results_ch.source)
	);

	// Mirror of the block's running congruence
	logic [63:0] acc_res;
	logic [63:0] acc_mod;
	logic        acc_fresh;
	status_t     acc_status;

	solution_t solutions_due[$];
	int  mismatch_cnt;
	int  stray_cnt;
	longint unsigned cycle_cnt = 0;
	int  burst_left;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// ---------------------------------------------------------------
	// Arithmetic for the predictor, products taken at 128 bits
	// ---------------------------------------------------------------
	function automatic logic [63:0] floor_mod(logic [63:0] v, logic [63:0] m);
		logic [63:0] mag;
		logic [63:0] r;
		if (!v[63])
			return v % m;
		mag = ~v + 64'd1;
		r = mag % m;
		return (r != 0) ? m - r : 64'd0;
	endfunction

	function automatic logic [63:0] gcd64(logic [63:0] a, logic [63:0] b);
		logic [63:0] t;
		while (b != 0) begin
			t = a % b;
			a = b;
			b = t;
		end
		return a;
	endfunction

	function automatic logic [63:0] mul_mod(logic [63:0] a, logic [63:0] b, logic [63:0] n);
		logic [127:0] p;
		p = {64'd0, a} * {64'd0, b};
		return 64'(p % {64'd0, n});
	endfunction

	// modular inverse by extended Euclid; u and n coprime, n >= 2
	function automatic logic [63:0] inverse_mod(logic [63:0] u, logic [63:0] n);
		logic signed [127:0] r0, r1, s0, s1, q, tmp, nn;
		nn = $signed({64'd0, n});
		r0 = $signed({64'd0, u % n});
		r1 = nn;
		s0 = 1;
		s1 = 0;
		while (r1 != 0) begin
			q = r0 / r1;
			tmp = r0 - q * r1;
			r0 = r1;
			r1 = tmp;
			tmp = s0 - q * s1;
			s0 = s1;
			s1 = tmp;
		end
		s0 = s0 % nn;
		if (s0 < 0)
			s0 = s0 + nn;
		return 64'(s0);
	endfunction

	// merge r2 mod m2 into the running congruence
	function automatic void merge_congruence(logic [63:0] r2, logic [63:0] m2);
		logic [63:0] g, d, a, n, k, t;
		logic neg;
		g = gcd64(acc_mod, m2);
		neg = r2 < acc_res;
		d = neg ? acc_res - r2 : r2 - acc_res;
		if (d % g != 0) begin
			acc_status = ST_CONFLICT;
			return;
		end
		a = acc_mod / g;
		if (a > MOD_CEIL / m2) begin
			acc_status = ST_OVERFLOW;
			return;
		end
		n = m2 / g;
		if (n == 1) begin
			t = 0;
		end else begin
			k = (d / g) % n;
			if (neg)
				k = (n - k) % n;
			t = mul_mod(k, inverse_mod(a, n), n);
		end
		acc_res = acc_res + acc_mod * t;
		acc_mod = a * m2;
	endfunction

	function automatic void clear_congruence();
		acc_res = 0;
		acc_mod = 1;
		acc_fresh = 1'b1;
		acc_status = ST_SOLVED;
	endfunction

	// fold one accepted congruence, queue a solution when it closes the system
	function automatic void fold_congruence(logic [63:0] residue, logic [62:0] modulus,
			logic last);
		logic [63:0] m;
		logic [63:0] r;
		solution_t sol;
		m = (modulus == 0) ? 64'd1 : {1'b0, modulus};
		r = floor_mod(residue, m);
		if (acc_fresh) begin
			acc_fresh = 1'b0;
			if (m > MOD_CEIL) begin
				acc_status = ST_OVERFLOW;
			end else begin
				acc_status = ST_SOLVED;
				acc_res = r;
				acc_mod = m;
			end
		end else if (acc_status == ST_SOLVED) begin
			if (m > MOD_CEIL)
				acc_status = ST_OVERFLOW;
			else
				merge_congruence(r, m);
		end
		if (!last)
			return;
		if (acc_status == ST_SOLVED) begin
			sol.sol_res = acc_res[62:0];
			sol.sol_mod = acc_mod[62:0];
		end else begin
			sol.sol_res = '0;
			sol.sol_mod = '0;
		end
		sol.status = acc_status;
		solutions_due.push_back(sol);
		clear_congruence();
	endfunction

	// ---------------------------------------------------------------
	// Sender side
	// ---------------------------------------------------------------
	// Caller sits just after a rising edge; returns at the accepting edge, or after the random gap that follows it.
	task automatic send_congruence(logic [63:0] residue, logic [62:0] modulus, logic last);
		logic took;
		items_ch.valid   <= 1'b1;
		items_ch.residue <= residue;
		items_ch.modulus <= modulus;
		items_ch.last    <= last;
		do begin
			@(negedge clk);
			took = items_ch.ready;
			@(posedge clk);
		end while (!took);
		fold_congruence(residue, modulus, last);
		// bursts with random gaps; some long bursts give gap-free stretches
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			int gap;
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
			if (gap > 0) begin
				items_ch.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 60)
				: $urandom_range(0, 8);
		end
	endtask

	// hold off until every solution in flight has come back
	task automatic drain_solutions();
		items_ch.valid <= 1'b0;
		@(posedge clk);
		while (solutions_due.size() != 0)
			@(posedge clk);
	endtask

	// ---------------------------------------------------------------
	// Receiver stall pattern: windows picked by cycle_cnt[9:8] with different moods
	// ---------------------------------------------------------------
	always @(posedge clk) begin
		case (cycle_cnt[9:8])
			2'd0: begin
				results_ch.ready <= 1'b1;
			end
			2'd1: begin
				results_ch.ready <= $urandom_range(0, 1);
			end
			2'd2: begin
				results_ch.ready <= (cycle_cnt[2:0] == 3'd0);
			end
			default: begin
				results_ch.ready <= (cycle_cnt[5:4] != 2'd3);
			end
		endcase
	end

	// ---------------------------------------------------------------
	// Result checker: sample between edges, score at the edge
	// ---------------------------------------------------------------
	always begin
		logic took;
		solution_t got, want;
		@(negedge clk);
		took = results_ch.valid && results_ch.ready;
		got.sol_res = results_ch.solution_residue;
		got.sol_mod = results_ch.solution_modulus;
		got.status = status_t'(results_ch.status);
		@(posedge clk);
		if (took === 1'b1) begin
			if (solutions_due.size() == 0) begin
				stray_cnt++;
				if (stray_cnt + mismatch_cnt <= 10)
					$display("unexpected solution transfer: res %0d mod %0d status %0d",
						got.sol_res, got.sol_mod, got.status);
			end else begin
				want = solutions_due.pop_front();
				if (got.sol_res !== want.sol_res || got.sol_mod !== want.sol_mod
						|| got.status !== want.status) begin
					mismatch_cnt++;
					if (stray_cnt + mismatch_cnt <= 10)
						$display({"mismatch: exp res %0d mod %0d status %0d, ",
							"got res %0d mod %0d status %0d"},
							want.sol_res, want.sol_mod, want.status,
							got.sol_res, got.sol_mod, got.status);
				end
			end
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt > CYCLE_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	// ---------------------------------------------------------------
	// Stimulus helpers
	// ---------------------------------------------------------------
	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	// mostly small moduli with shared factors; a few huge ones, zero and one
	function automatic logic [62:0] pick_modulus();
		int sel;
		sel = $urandom_range(0, 99);
		if (sel < 3)
			return 63'(rand64());
		else if (sel < 6)
			return '0;
		else if (sel < 10)
			return 63'd1;
		else
			return 63'($urandom_range(1, 12) * $urandom_range(1, 60));
	endfunction

	// residue that agrees with x modulo m, for small m shifted by a random signed multiple of m
	function automatic logic [63:0] agreeing_residue(logic [63:0] x, logic [62:0] modulus);
		logic [63:0] m;
		longint k;
		m = (modulus == 0) ? 64'd1 : {1'b0, modulus};
		if (m > 64'd100000)
			return x % m;
		k = longint'($urandom_range(0, 2000)) - 1000;
		return 64'(longint'(x % m) + longint'(m) * k);
	endfunction

	// ---------------------------------------------------------------
	// Tests
	// ---------------------------------------------------------------
	task automatic test_basic_systems();
		// single item: negative residue folds to its floor residue
		send_congruence(-64'sd1, 63'd7, 1'b1);
		// zero modulus acts as modulus one
		send_congruence(64'd5, 63'd0, 1'b1);
		// coprime moduli: x = 23 mod 105
		send_congruence(64'd2, 63'd3, 1'b0);
		send_congruence(64'd3, 63'd5, 1'b0);
		send_congruence(64'd2, 63'd7, 1'b1);
		// shared factor, consistent: x = 10 mod 12
		send_congruence(64'd2, 63'd4, 1'b0);
		send_congruence(-64'sd2, 63'd6, 1'b1);
		// same modulus twice, second one redundant
		send_congruence(64'd9, 63'd10, 1'b0);
		send_congruence(64'd19, 63'd10, 1'b1);
	endtask

	task automatic test_failures();
		// conflict, then an item that must be skipped
		send_congruence(64'd1, 63'd4, 1'b0);
		send_congruence(64'd2, 63'd6, 1'b0);
		send_congruence(64'd5, 63'd9, 1'b1);
		// lcm overflow, then a conflicting item; overflow is the first failure
		send_congruence(64'h8000_0000_0000_0000, 63'h7FFF_FFFF_FFFF_FFFF, 1'b0);
		send_congruence(64'd1, 63'd2, 1'b0);
		send_congruence(64'd0, 63'd2, 1'b1);
		// the block must rearm cleanly after a failed system
		send_congruence(64'd4, 63'd9, 1'b1);
	endtask

	task automatic test_extremes();
		send_congruence(64'h7FFF_FFFF_FFFF_FFFF, 63'h7FFF_FFFF_FFFF_FFFF, 1'b1);
		send_congruence(64'h8000_0000_0000_0000, 63'h7FFF_FFFF_FFFF_FFFF, 1'b1);
		send_congruence(64'h8000_0000_0000_0000, 63'd1, 1'b1);
		send_congruence(64'hFFFF_FFFF_FFFF_FFFF, 63'h4000_0000_0000_0000, 1'b0);
		send_congruence(64'h0000_0000_0000_0003, 63'd2, 1'b1);
		send_congruence(64'h5555_5555_5555_5555, 63'h2AAA_AAAA_AAAA_AAAA, 1'b1);
		send_congruence(64'hAAAA_AAAA_AAAA_AAAA, 63'h5555_5555_5555_5555, 1'b1);
	endtask

	task automatic test_random_systems(int budget);
		int sent;
		int len;
		int mood;
		logic [63:0] secret;
		logic [62:0] m;
		sent = 0;
		while (sent < budget) begin
			len = $urandom_range(1, 5);
			mood = $urandom_range(0, 99);
			secret = rand64();
			for (int i = 0; i < len; i++) begin
				m = pick_modulus();
				if (mood < 70)
					send_congruence(agreeing_residue(secret, m), m, i == len - 1);
				else if (mood < 85)
					send_congruence(64'($urandom_range(0, 50)) - 64'd25, m, i == len - 1);
				else
					send_congruence(rand64(), (mood < 95) ? m : 63'(rand64()),
						i == len - 1);
			end
			sent += len;
			if (sent >= budget / 2 && sent - len < budget / 2)
				drain_solutions();
		end
	endtask

	// ---------------------------------------------------------------
	// Main sequence
	// ---------------------------------------------------------------
	initial begin
		arst_n <= 1'b0;
		items_ch.valid <= 1'b0;
		items_ch.residue <= '0;
		items_ch.modulus <= '0;
		items_ch.last <= 1'b0;
		mismatch_cnt = 0;
		stray_cnt = 0;
		burst_left = 0;
		clear_congruence();
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_basic_systems();
		test_failures();
		test_extremes();
		drain_solutions();
		test_random_systems(1145);

		drain_solutions();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatch_cnt == 0 && stray_cnt == 0 && solutions_due.size() == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule
